### hw/rtl/ddcs_pkg.sv
// Package for the disk drive command and status unit.
// Holds function and readback codes, flag bit positions, register indexes and
// the command and result structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ddcs_pkg;

    localparam int NUM_DRIVES_DEF = 8;

    localparam int CYL_W  = 10;
    localparam int HEAD_W = 2;
    localparam int FLAG_W = 6;

    localparam logic [CYL_W-1:0] MAX_CYL_RESET = 10'd353;
    localparam logic [7:0]       PRESENT_RESET = 8'h01;
    localparam logic [3:0]       UNIT_ID_RESET = 4'h0;

    // func codes
    localparam logic [2:0] FUNC_SELECT   = 3'd0;
    localparam logic [2:0] FUNC_CYL_LOW  = 3'd1;
    localparam logic [2:0] FUNC_REZERO   = 3'd2;
    localparam logic [2:0] FUNC_READBACK = 3'd3;
    localparam logic [2:0] FUNC_SEEK_SVC = 3'd4;

    // readback selects
    localparam logic [1:0] RSEL_STATUS1 = 2'd0;
    localparam logic [1:0] RSEL_STATUS2 = 2'd1;
    localparam logic [1:0] RSEL_CYL_LO  = 2'd2;
    localparam logic [1:0] RSEL_ID_HEAD = 2'd3;

    // rezero / fault clear command bits
    localparam int CMD_REZERO_BIT = 1;
    localparam int CMD_FCLEAR_BIT = 0;

    // drive flag bit positions
    localparam int FLG_ONCYL   = 0;
    localparam int FLG_SEEK    = 1;
    localparam int FLG_REZERO  = 2;
    localparam int FLG_ILLEGAL = 3;
    localparam int FLG_FAULT   = 4;
    localparam int FLG_UNSAFE  = 5;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_DRIVE_PRESENT = 2'd0;
    localparam logic [1:0] REG_MAX_CYLINDER  = 2'd1;
    localparam logic [1:0] REG_UNIT_ID       = 2'd2;

    typedef struct packed {
        logic load_in;   // capture the input word
        logic commit;    // update drive state and load the result register
    } dp_cmd_t;

    typedef struct packed {
        logic       seek_done;
        logic       rw_unsafe;
        logic       rw_fault;
        logic       illegal_address;
        logic       rezeroing;
        logic       seeking;
        logic       on_cylinder;
        logic       selected;
        logic [7:0] rd_byte;
        logic       read_valid;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/ddcs_ctrl.sv
// Controller for the disk drive command and status unit.
// Sequences capture and execute of one input word and owns the result valid.
// Depends on ddcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddcs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output ddcs_pkg::dp_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.load_in    = 1'b0;
        cmd.commit     = 1'b0;
        s_tready       = 1'b0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register can take a new word
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_accept_to_exec : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted word did not move to execute");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_commit_valid : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not marked valid");

    a_single_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_in && cmd.commit))
        else $error("capture and commit in the same cycle");

endmodule

`default_nettype wire

### hw/rtl/ddcs_dpath.sv
// Datapath for the disk drive command and status unit.
// Per-drive position and flag registers, function decode and result register.
// Depends on ddcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddcs_dpath #(
    parameter int NUM_DRIVES = ddcs_pkg::NUM_DRIVES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ddcs_pkg::dp_cmd_t           cmd,
    input  wire logic [2:0]                  func,
    input  wire logic [7:0]                  data,
    input  wire logic [1:0]                  read_sel,
    input  wire logic                        load_ok,
    input  wire logic [7:0]                  drive_present,
    input  wire logic [ddcs_pkg::CYL_W-1:0]  max_cylinder,
    input  wire logic [3:0]                  unit_id,
    output ddcs_pkg::result_t                result
);

    localparam int IDX_W = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;

    // captured input word
    logic [2:0] func_reg;
    logic [7:0] data_reg;
    logic [1:0] rsel_reg;
    logic       ok_reg;

    // per-drive state
    logic [ddcs_pkg::CYL_W-1:0]  tcyl_reg [NUM_DRIVES];
    logic [ddcs_pkg::HEAD_W-1:0] thead_reg[NUM_DRIVES];
    logic [ddcs_pkg::CYL_W-1:0]  ccyl_reg [NUM_DRIVES];
    logic [ddcs_pkg::HEAD_W-1:0] chead_reg[NUM_DRIVES];
    logic [ddcs_pkg::FLAG_W-1:0] flags_reg[NUM_DRIVES];
    logic [IDX_W-1:0]            active_reg, active_next;
    logic                        sel_reg, sel_next;

    ddcs_pkg::result_t           result_reg, result_next;

    logic [3:0]                  unit;
    logic                        exists;
    logic [IDX_W-1:0]            idx;
    logic [ddcs_pkg::CYL_W-1:0]  tc, tc_next, cc, cc_next;
    logic [ddcs_pkg::HEAD_W-1:0] th, th_next, ch, ch_next;
    logic [ddcs_pkg::FLAG_W-1:0] fl, fl_next;
    logic                        rvalid, done;
    logic [7:0]                  rdata;

    assign unit   = data_reg[7:4];
    assign exists = (unit < 4'(NUM_DRIVES)) && drive_present[unit[2:0]];
    // one entry is touched per word: the newly selected unit or the active one
    assign idx    = (func_reg == ddcs_pkg::FUNC_SELECT && exists) ? unit[IDX_W-1:0]
                                                                : active_reg;

    assign tc = tcyl_reg[idx];
    assign th = thead_reg[idx];
    assign cc = ccyl_reg[idx];
    assign ch = chead_reg[idx];
    assign fl = flags_reg[idx];

    always_comb
    begin
        tc_next     = tc;
        th_next     = th;
        cc_next     = cc;
        ch_next     = ch;
        fl_next     = fl;
        active_next = active_reg;
        sel_next    = sel_reg;
        rvalid      = 1'b0;
        rdata       = 8'h00;
        done        = 1'b0;
        case (func_reg)
            ddcs_pkg::FUNC_SELECT:
            begin
                if (exists)
                begin
                    th_next     = data_reg[3:2];
                    tc_next     = {data_reg[1:0], tc[7:0]};
                    active_next = idx;
                    sel_next    = 1'b1;
                end
                else
                begin
                    sel_next = 1'b0;
                end
            end
            ddcs_pkg::FUNC_CYL_LOW:
            begin
                if (sel_reg)
                begin
                    tc_next = {tc[9:8], data_reg};
                    if (tc_next > max_cylinder)
                    begin
                        fl_next[ddcs_pkg::FLG_ILLEGAL] = 1'b1;
                    end
                    else
                    begin
                        fl_next[ddcs_pkg::FLG_ILLEGAL] = 1'b0;
                        fl_next[ddcs_pkg::FLG_ONCYL]   = 1'b0;
                        fl_next[ddcs_pkg::FLG_SEEK]    = 1'b1;
                    end
                end
            end
            ddcs_pkg::FUNC_REZERO:
            begin
                if (sel_reg)
                begin
                    // rezero wins over fault clear
                    if (data_reg[ddcs_pkg::CMD_REZERO_BIT])
                    begin
                        fl_next[ddcs_pkg::FLG_ILLEGAL] = 1'b0;
                        fl_next[ddcs_pkg::FLG_ONCYL]   = 1'b0;
                        fl_next[ddcs_pkg::FLG_FAULT]   = 1'b0;
                        fl_next[ddcs_pkg::FLG_UNSAFE]  = 1'b0;
                        fl_next[ddcs_pkg::FLG_SEEK]    = 1'b1;
                        fl_next[ddcs_pkg::FLG_REZERO]  = 1'b1;
                        tc_next                        = '0;
                        th_next                        = '0;
                    end
                    else if (data_reg[ddcs_pkg::CMD_FCLEAR_BIT])
                    begin
                        fl_next[ddcs_pkg::FLG_FAULT]  = 1'b0;
                        fl_next[ddcs_pkg::FLG_UNSAFE] = 1'b0;
                    end
                end
            end
            ddcs_pkg::FUNC_READBACK:
            begin
                if (sel_reg)
                begin
                    rvalid = 1'b1;
                    case (rsel_reg)
                        ddcs_pkg::RSEL_STATUS1: rdata = {3'b000, fl[4:0]};
                        ddcs_pkg::RSEL_STATUS2: rdata = {7'b0, fl[ddcs_pkg::FLG_UNSAFE]};
                        ddcs_pkg::RSEL_CYL_LO:  rdata = cc[7:0];
                        ddcs_pkg::RSEL_ID_HEAD: rdata = {unit_id, ch, cc[9:8]};
                        default:                rdata = 8'h00;
                    endcase
                end
            end
            ddcs_pkg::FUNC_SEEK_SVC:
            begin
                // acts on the active drive even when deselected
                if (fl[ddcs_pkg::FLG_SEEK])
                begin
                    if (ch != th || cc != tc)
                    begin
                        cc_next = tc;
                        ch_next = th;
                        if (ok_reg)
                        begin
                            fl_next[ddcs_pkg::FLG_ONCYL] = 1'b1;
                        end
                        else
                        begin
                            fl_next[ddcs_pkg::FLG_FAULT] = 1'b1;
                        end
                    end
                    else
                    begin
                        fl_next[ddcs_pkg::FLG_ONCYL] = 1'b1;
                    end
                    fl_next[ddcs_pkg::FLG_SEEK]   = 1'b0;
                    fl_next[ddcs_pkg::FLG_REZERO] = 1'b0;
                    done                          = 1'b1;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result_next.read_valid      = rvalid;
        result_next.rd_byte         = rdata;
        result_next.selected        = sel_next;
        result_next.on_cylinder     = fl_next[ddcs_pkg::FLG_ONCYL];
        result_next.seeking         = fl_next[ddcs_pkg::FLG_SEEK];
        result_next.rezeroing       = fl_next[ddcs_pkg::FLG_REZERO];
        result_next.illegal_address = fl_next[ddcs_pkg::FLG_ILLEGAL];
        result_next.rw_fault        = fl_next[ddcs_pkg::FLG_FAULT];
        result_next.rw_unsafe       = fl_next[ddcs_pkg::FLG_UNSAFE];
        result_next.seek_done       = done;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= func;
            data_reg <= data;
            rsel_reg <= read_sel;
            ok_reg   <= load_ok;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DRIVES; i++)
            begin
                tcyl_reg[i]  <= '0;
                thead_reg[i] <= '0;
                ccyl_reg[i]  <= '0;
                chead_reg[i] <= '0;
                flags_reg[i] <= '0;
            end
            active_reg <= '0;
            sel_reg    <= 1'b0;
        end
        else if (cmd.commit)
        begin
            tcyl_reg[idx]  <= tc_next;
            thead_reg[idx] <= th_next;
            ccyl_reg[idx]  <= cc_next;
            chead_reg[idx] <= ch_next;
            flags_reg[idx] <= fl_next;
            active_reg     <= active_next;
            sel_reg        <= sel_next;
        end
    end

    assign result = result_reg;

    a_seek_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && done) |=> !flags_reg[$past(idx)][ddcs_pkg::FLG_SEEK])
        else $error("serviced seek left seeking set");

    a_done_needs_seek : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (func_reg == ddcs_pkg::FUNC_SEEK_SVC && fl[ddcs_pkg::FLG_SEEK]))
        else $error("seek complete without a pending seek");

    a_read_needs_sel : assert property (@(posedge clk) disable iff (!rst_n)
        rvalid |-> sel_reg)
        else $error("readback answered with no drive selected");

endmodule

`default_nettype wire

### hw/rtl/disk_drive_command_status_unit.sv
// Top level of the disk drive command and status unit.
// Holds the configuration registers and joins ddcs_ctrl and ddcs_dpath.
// Depends on ddcs_pkg, ddcs_ctrl, ddcs_dpath.
//
//   channel   direction  handshake                      payload
//   s_*       in         s_tvalid / s_tready            s_tdata: command word
//   m_*       out        m_tvalid / m_tready            m_tdata: result word
//   apb       in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Each word is captured in idle, then decoded in execute, where the selected drive's
// entry is updated; the steps are set by the two-state controller.
// The result register frees s_tready: a new word is taken while a result waits.
// A stall on m_tready holds the next word in execute until the waiting result leaves.
// Reset clears all per-drive state at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module disk_drive_command_status_unit #(
    parameter int NUM_DRIVES = ddcs_pkg::NUM_DRIVES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // func[2:0], data[10:3], read_sel[12:11], load_ok[13], zero[15:14]
    input  wire logic [15:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_valid[0], rd_byte[8:1], selected[9], on_cylinder[10], seeking[11],
    // rezeroing[12], illegal_address[13], rw_fault[14], rw_unsafe[15],
    // seek_done[16], zero[23:17]
    output logic [23:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]                 present_reg;
    logic [ddcs_pkg::CYL_W-1:0] max_cyl_reg;
    logic [3:0]                 unit_id_reg;
    logic                       wr_en;

    ddcs_pkg::dp_cmd_t          cmd;
    ddcs_pkg::result_t          res;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= ddcs_pkg::PRESENT_RESET;
            max_cyl_reg <= ddcs_pkg::MAX_CYL_RESET;
            unit_id_reg <= ddcs_pkg::UNIT_ID_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                ddcs_pkg::REG_DRIVE_PRESENT: present_reg <= pwdata[7:0];
                ddcs_pkg::REG_MAX_CYLINDER:  max_cyl_reg <= pwdata[ddcs_pkg::CYL_W-1:0];
                ddcs_pkg::REG_UNIT_ID:       unit_id_reg <= pwdata[3:0];
                default:                     present_reg <= present_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            ddcs_pkg::REG_DRIVE_PRESENT: prdata = {24'b0, present_reg};
            ddcs_pkg::REG_MAX_CYLINDER:  prdata = {22'b0, max_cyl_reg};
            ddcs_pkg::REG_UNIT_ID:       prdata = {28'b0, unit_id_reg};
            default:                     prdata = 32'b0;
        endcase
    end

    ddcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ddcs_dpath #(
        .NUM_DRIVES (NUM_DRIVES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (s_tdata[2:0]),
        .data          (s_tdata[10:3]),
        .read_sel      (s_tdata[12:11]),
        .load_ok       (s_tdata[13]),
        .drive_present (present_reg),
        .max_cylinder  (max_cyl_reg),
        .unit_id       (unit_id_reg),
        .result        (res)
    );

    assign m_tdata = {7'b0, res.seek_done, res.rw_unsafe, res.rw_fault,
                      res.illegal_address, res.rezeroing, res.seeking,
                      res.on_cylinder, res.selected, res.rd_byte, res.read_valid};

endmodule

`default_nettype wire
